>>> hw/rtl/axis_angle_rotation_matrix_macros.svh
// Assertion macros for the rotation matrix block.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`ifndef ASSERT_OFF
`define ARM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m: lbl");
`define ARM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: lbl");
`else
`define ARM_ASSERT(lbl, clk, rst_n, prop)
`define ARM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/aarm_pkg.sv
`default_nettype none
package aarm_pkg;
  localparam int unsigned FracBitsDef    = 14;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned Wq             = 30;
  localparam logic signed [33:0] PiQ     = 34'sd3373259426;
  localparam logic signed [33:0] HalfPiQ = 34'sd1686629713;
  localparam logic signed [33:0] GainQ   = 34'sd652032874;
  localparam logic signed [33:0] OneQ    = 34'sd1073741824;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic               zero_axis;
  } out_t;

  function automatic logic signed [33:0] atan_q(input logic [4:0] i);
    logic signed [33:0] t;
    case (i)
      5'd0: t = 34'sd843314857;   5'd1: t = 34'sd497837829;
      5'd2: t = 34'sd263043837;   5'd3: t = 34'sd133525159;
      5'd4: t = 34'sd67021687;    5'd5: t = 34'sd33543516;
      5'd6: t = 34'sd16775851;    5'd7: t = 34'sd8388437;
      5'd8: t = 34'sd4194283;     5'd9: t = 34'sd2097149;
      5'd31: t = 34'sd1;
      default: t = 34'sd1 <<< (5'd30 - i);
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/aarm_pipe.sv
`default_nettype none
// Generic stalling pipeline register: holds a payload with a valid bit.
module aarm_pipe #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  valid_o,
  output logic [Width-1:0]      data_o
);
  logic             valid_q;
  logic [Width-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

>>> hw/rtl/axis_angle_rotation_matrix.sv
`default_nettype none
// Axis-angle to rotation matrix (Rodrigues). Each request carries an axis
// (Q2.14, any nonzero length) and an angle (Q3.13 radians) and yields one
// row-major 3x3 matrix in Q1.FracBits, saturated to +-1; a zero axis gives
// the identity with zero_axis set. The block is a single stalling pipeline:
// one request enters every cycle and a result leaves every cycle while the
// output is not held. Its stages are the front stage, the bit-serial square
// root (one root bit per stage), the restoring divider (one quotient bit per
// stage, shared by the three axis components side by side) and four tail
// stages (clamp, two product stages, output register). The CORDIC runs one
// iteration per stage in parallel with the root and the divider, riding in
// their stages. ready falls only while the output register holds a result
// not yet taken; the whole pipe then freezes.
`include "axis_angle_rotation_matrix_macros.svh"
module axis_angle_rotation_matrix #(
  parameter int unsigned FracBits    = aarm_pkg::FracBitsDef,
  parameter int unsigned CordicSteps = aarm_pkg::CordicStepsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire aarm_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output aarm_pkg::out_t      out_data_o
);
  localparam int unsigned SqSteps  = 32;  // root bits of s*2^28 (< 2^64)
  localparam int unsigned DivSteps = 46;  // quotient bits of mag*2^44/n
  localparam int unsigned CorW     = 34;

  // Freeze every stage when the output is held.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- front: squares and angle fold ----------------
  typedef struct packed {
    logic signed [15:0] ax, ay, az;
    logic [33:0]        ss;
    logic signed [CorW-1:0] th;
    logic neg, zero;
  } s0_t;
  s0_t s0_d, s0_q;
  logic s0_v;
  logic signed [CorW-1:0] th_raw;

  always_comb begin
    th_raw    = CorW'(in_data_i.angle) <<< 17;
    s0_d.ax   = in_data_i.axis_x;
    s0_d.ay   = in_data_i.axis_y;
    s0_d.az   = in_data_i.axis_z;
    s0_d.ss   = 34'(32'(in_data_i.axis_x * in_data_i.axis_x))
              + 34'(32'(in_data_i.axis_y * in_data_i.axis_y))
              + 34'(32'(in_data_i.axis_z * in_data_i.axis_z));
    s0_d.zero = (in_data_i.axis_x == '0) && (in_data_i.axis_y == '0)
             && (in_data_i.axis_z == '0);
    s0_d.neg  = 1'b0;
    s0_d.th   = th_raw;
    if (th_raw > aarm_pkg::HalfPiQ) begin
      s0_d.th = th_raw - aarm_pkg::PiQ; s0_d.neg = 1'b1;
    end else if (th_raw < -aarm_pkg::HalfPiQ) begin
      s0_d.th = th_raw + aarm_pkg::PiQ; s0_d.neg = 1'b1;
    end
  end

  aarm_pipe #(.Width($bits(s0_t))) u_s0 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_valid_i), .data_i(s0_d),
    .valid_o(s0_v), .data_o(s0_q)
  );

  // ---------------- square root, one root bit per stage ----------------
  // Runs as restoring sqrt on v = ss<<28; CORDIC iterations ride alongside.
  typedef struct packed {
    logic signed [15:0] ax, ay, az;
    logic [63:0] rem;
    logic [31:0] root;
    logic signed [CorW-1:0] cx, cy, cz;
    logic [5:0]  it;
    logic neg, zero;
  } sq_t;

  sq_t sq_d [SqSteps];
  sq_t sq_q [SqSteps+1];
  logic sq_v [SqSteps+1];

  always_comb begin
    sq_q[0]      = '0;
    sq_q[0].ax   = s0_q.ax;
    sq_q[0].ay   = s0_q.ay;
    sq_q[0].az   = s0_q.az;
    sq_q[0].rem  = {2'b00, s0_q.ss, 28'd0};
    sq_q[0].root = '0;
    sq_q[0].cx   = aarm_pkg::GainQ;
    sq_q[0].cy   = '0;
    sq_q[0].cz   = s0_q.th;
    sq_q[0].it   = '0;
    sq_q[0].neg  = s0_q.neg;
    sq_q[0].zero = s0_q.zero;
    sq_v[0]      = s0_v;
  end

  for (genvar g = 0; g < SqSteps; g++) begin : g_sq
    logic [65:0] trial;
    logic [65:0] remw;
    logic [4:0]  sh;
    always_comb begin
      sq_d[g] = sq_q[g];
      // Root bit b = 31-g; compare (2*root*2^b + 2^(2b)) to remainder.
      remw  = {2'b00, sq_q[g].rem};
      trial = ({34'd0, sq_q[g].root} << (32 - g))
            + (66'd1 << (62 - 2 * g));
      if (remw >= trial) begin
        sq_d[g].rem  = 64'(remw - trial);
        sq_d[g].root = sq_q[g].root | (32'd1 << (31 - g));
      end
      // CORDIC step while iterations remain.
      sh = sq_q[g].it[4:0];
      if (32'(sq_q[g].it) < CordicSteps) begin
        if (!sq_q[g].cz[CorW-1]) begin
          sq_d[g].cx = sq_q[g].cx - (sq_q[g].cy >>> sh);
          sq_d[g].cy = sq_q[g].cy + (sq_q[g].cx >>> sh);
          sq_d[g].cz = sq_q[g].cz - aarm_pkg::atan_q(sh);
        end else begin
          sq_d[g].cx = sq_q[g].cx + (sq_q[g].cy >>> sh);
          sq_d[g].cy = sq_q[g].cy - (sq_q[g].cx >>> sh);
          sq_d[g].cz = sq_q[g].cz + aarm_pkg::atan_q(sh);
        end
        sq_d[g].it = sq_q[g].it + 6'd1;
      end
    end
    aarm_pipe #(.Width($bits(sq_t))) u_st (
      .clk_i, .rst_ni, .en_i(adv), .valid_i(sq_v[g]), .data_i(sq_d[g]),
      .valid_o(sq_v[g+1]), .data_o(sq_q[g+1])
    );
  end

  // ---------------- division, one quotient bit per stage ----------------
  typedef struct packed {
    logic [2:0]   sgn;
    logic [47:0]  rem0, rem1, rem2;
    logic [59:0]  num0, num1, num2;
    logic [45:0]  q0, q1, q2;
    logic [31:0]  n;
    logic signed [CorW-1:0] cx, cy, cz;
    logic [5:0]   it;
    logic neg, zero;
  } dv_t;

  dv_t dv_d [DivSteps];
  dv_t dv_q [DivSteps+1];
  logic dv_v [DivSteps+1];
  logic [15:0] mag0, mag1, mag2;

  always_comb begin
    mag0 = sq_q[SqSteps].ax[15] ? 16'(-sq_q[SqSteps].ax) : sq_q[SqSteps].ax;
    mag1 = sq_q[SqSteps].ay[15] ? 16'(-sq_q[SqSteps].ay) : sq_q[SqSteps].ay;
    mag2 = sq_q[SqSteps].az[15] ? 16'(-sq_q[SqSteps].az) : sq_q[SqSteps].az;
    dv_q[0]      = '0;
    dv_q[0].sgn  = {sq_q[SqSteps].az[15], sq_q[SqSteps].ay[15], sq_q[SqSteps].ax[15]};
    // numerator = mag*2^44 + n/2 (fits in 60 bits)
    dv_q[0].num0 = {mag0, 44'd0} + 60'(sq_q[SqSteps].root >> 1);
    dv_q[0].num1 = {mag1, 44'd0} + 60'(sq_q[SqSteps].root >> 1);
    dv_q[0].num2 = {mag2, 44'd0} + 60'(sq_q[SqSteps].root >> 1);
    dv_q[0].n    = sq_q[SqSteps].root;
    dv_q[0].cx   = sq_q[SqSteps].cx;
    dv_q[0].cy   = sq_q[SqSteps].cy;
    dv_q[0].cz   = sq_q[SqSteps].cz;
    dv_q[0].it   = sq_q[SqSteps].it;
    dv_q[0].neg  = sq_q[SqSteps].neg;
    dv_q[0].zero = sq_q[SqSteps].zero;
    dv_v[0]      = sq_v[SqSteps];
  end

  // Quotient < 2^46 once n >= 2^14 (nonzero axis); zero axis is overridden.
  for (genvar g = 0; g < DivSteps; g++) begin : g_dv
    logic [47:0] t0, t1, t2;
    logic [4:0]  sh;
    always_comb begin
      dv_d[g] = dv_q[g];
      t0 = {dv_q[g].rem0[46:0], dv_q[g].num0[DivSteps-1-g]};
      t1 = {dv_q[g].rem1[46:0], dv_q[g].num1[DivSteps-1-g]};
      t2 = {dv_q[g].rem2[46:0], dv_q[g].num2[DivSteps-1-g]};
      if (g == 0) begin
        // top bits of numerator above the quotient window
        t0 = {33'd0, dv_q[g].num0[59:DivSteps-1]};
        t1 = {33'd0, dv_q[g].num1[59:DivSteps-1]};
        t2 = {33'd0, dv_q[g].num2[59:DivSteps-1]};
      end
      dv_d[g].rem0 = t0; dv_d[g].rem1 = t1; dv_d[g].rem2 = t2;
      if (t0 >= 48'(dv_q[g].n)) begin
        dv_d[g].rem0 = t0 - 48'(dv_q[g].n);
        dv_d[g].q0[DivSteps-1-g] = 1'b1;
      end
      if (t1 >= 48'(dv_q[g].n)) begin
        dv_d[g].rem1 = t1 - 48'(dv_q[g].n);
        dv_d[g].q1[DivSteps-1-g] = 1'b1;
      end
      if (t2 >= 48'(dv_q[g].n)) begin
        dv_d[g].rem2 = t2 - 48'(dv_q[g].n);
        dv_d[g].q2[DivSteps-1-g] = 1'b1;
      end
      sh = dv_q[g].it[4:0];
      if (32'(dv_q[g].it) < CordicSteps) begin
        if (!dv_q[g].cz[CorW-1]) begin
          dv_d[g].cx = dv_q[g].cx - (dv_q[g].cy >>> sh);
          dv_d[g].cy = dv_q[g].cy + (dv_q[g].cx >>> sh);
          dv_d[g].cz = dv_q[g].cz - aarm_pkg::atan_q(sh);
        end else begin
          dv_d[g].cx = dv_q[g].cx + (dv_q[g].cy >>> sh);
          dv_d[g].cy = dv_q[g].cy - (dv_q[g].cx >>> sh);
          dv_d[g].cz = dv_q[g].cz + aarm_pkg::atan_q(sh);
        end
        dv_d[g].it = dv_q[g].it + 6'd1;
      end
    end
    aarm_pipe #(.Width($bits(dv_t))) u_st (
      .clk_i, .rst_ni, .en_i(adv), .valid_i(dv_v[g]), .data_i(dv_d[g]),
      .valid_o(dv_v[g+1]), .data_o(dv_q[g+1])
    );
  end

  // ---------------- clamp, sign, sin/cos ----------------
  // 1-cos reaches 2 when cos is near -1, so it carries 34 bits.
  typedef struct packed {
    logic signed [31:0] u0, u1, u2;
    logic signed [31:0] c, s;
    logic signed [33:0] omc;
    logic zero;
  } ca_t;
  ca_t ca_d, ca_q;
  logic ca_v;
  logic [45:0] qq [3];
  logic [2:0]  sg;
  logic signed [31:0] uu [3];
  logic signed [CorW-1:0] cc, sv;

  // Remaining CORDIC steps (if more than the sqrt+div stages) are not
  // needed: CordicSteps <= 32 < SqSteps + DivSteps.
  always_comb begin
    qq[0] = dv_q[DivSteps].q0;
    qq[1] = dv_q[DivSteps].q1;
    qq[2] = dv_q[DivSteps].q2;
    sg    = dv_q[DivSteps].sgn;
    for (int k = 0; k < 3; k++) begin
      uu[k] = (qq[k] > 46'd1073741824) ? 32'sd1073741824 : 32'(qq[k]);
      if (sg[k]) uu[k] = -uu[k];
    end
    cc = dv_q[DivSteps].neg ? -dv_q[DivSteps].cx : dv_q[DivSteps].cx;
    sv = dv_q[DivSteps].neg ? -dv_q[DivSteps].cy : dv_q[DivSteps].cy;
    ca_d.u0   = uu[0];
    ca_d.u1   = uu[1];
    ca_d.u2   = uu[2];
    ca_d.c    = 32'(cc);
    ca_d.s    = 32'(sv);
    ca_d.omc  = aarm_pkg::OneQ - cc;
    ca_d.zero = dv_q[DivSteps].zero;
  end

  aarm_pipe #(.Width($bits(ca_t))) u_ca (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(dv_v[DivSteps]), .data_i(ca_d),
    .valid_o(ca_v), .data_o(ca_q)
  );

  // ---------------- products: u_r*u_k and sin*(+-u) ----------------
  // Round sin*(-u) on its own: round half up is not symmetric in sign.
  typedef struct packed {
    logic signed [31:0] p00, p01, p02, p11, p12, p22;
    logic signed [31:0] su0, su1, su2;
    logic signed [31:0] nsu0, nsu1, nsu2;
    logic signed [31:0] c;
    logic signed [33:0] omc;
    logic zero;
  } pa_t;
  pa_t pa_d, pa_q;
  logic pa_v;

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return 32'(p >>> 30);
  endfunction

  function automatic logic signed [33:0] qmul_wide(input logic signed [33:0] a,
                                                   input logic signed [31:0] b);
    logic signed [65:0] p;
    p = a * b + 66'sd536870912;
    return 34'(p >>> 30);
  endfunction

  always_comb begin
    pa_d.p00  = qmul(ca_q.u0, ca_q.u0);
    pa_d.p01  = qmul(ca_q.u0, ca_q.u1);
    pa_d.p02  = qmul(ca_q.u0, ca_q.u2);
    pa_d.p11  = qmul(ca_q.u1, ca_q.u1);
    pa_d.p12  = qmul(ca_q.u1, ca_q.u2);
    pa_d.p22  = qmul(ca_q.u2, ca_q.u2);
    pa_d.su0  = qmul(ca_q.s, ca_q.u0);
    pa_d.su1  = qmul(ca_q.s, ca_q.u1);
    pa_d.su2  = qmul(ca_q.s, ca_q.u2);
    pa_d.nsu0 = qmul(ca_q.s, -ca_q.u0);
    pa_d.nsu1 = qmul(ca_q.s, -ca_q.u1);
    pa_d.nsu2 = qmul(ca_q.s, -ca_q.u2);
    pa_d.c    = ca_q.c;
    pa_d.omc  = ca_q.omc;
    pa_d.zero = ca_q.zero;
  end

  aarm_pipe #(.Width($bits(pa_t))) u_pa (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(ca_v), .data_i(pa_d),
    .valid_o(pa_v), .data_o(pa_q)
  );

  // ---------------- (1-cos) scaling ----------------
  typedef struct packed {
    logic signed [33:0] m00, m01, m02, m11, m12, m22;
    logic signed [31:0] su0, su1, su2;
    logic signed [31:0] nsu0, nsu1, nsu2;
    logic signed [31:0] c;
    logic zero;
  } pb_t;
  pb_t pb_d, pb_q;
  logic pb_v;

  always_comb begin
    pb_d.m00  = qmul_wide(pa_q.omc, pa_q.p00);
    pb_d.m01  = qmul_wide(pa_q.omc, pa_q.p01);
    pb_d.m02  = qmul_wide(pa_q.omc, pa_q.p02);
    pb_d.m11  = qmul_wide(pa_q.omc, pa_q.p11);
    pb_d.m12  = qmul_wide(pa_q.omc, pa_q.p12);
    pb_d.m22  = qmul_wide(pa_q.omc, pa_q.p22);
    pb_d.su0  = pa_q.su0;
    pb_d.su1  = pa_q.su1;
    pb_d.su2  = pa_q.su2;
    pb_d.nsu0 = pa_q.nsu0;
    pb_d.nsu1 = pa_q.nsu1;
    pb_d.nsu2 = pa_q.nsu2;
    pb_d.c    = pa_q.c;
    pb_d.zero = pa_q.zero;
  end

  aarm_pipe #(.Width($bits(pb_t))) u_pb (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(pa_v), .data_i(pb_d),
    .valid_o(pb_v), .data_o(pb_q)
  );

  // ---------------- sums, rounding, saturation: output register ----------
  function automatic logic [15:0] to_out(input logic signed [33:0] v);
    logic signed [33:0] r;
    logic signed [33:0] one;
    one = 34'sd1 <<< FracBits;
    r   = (v + (34'sd1 <<< (aarm_pkg::Wq - FracBits - 1))) >>> (aarm_pkg::Wq - FracBits);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

  function automatic logic signed [33:0] sx(input logic signed [31:0] a);
    return 34'(a);
  endfunction

  aarm_pkg::out_t res_d;
  logic [15:0]    ident;

  always_comb begin
    ident = 16'(34'sd1 <<< FracBits);
    res_d.r00 = to_out(pb_q.m00 + sx(pb_q.c));
    res_d.r01 = to_out(pb_q.m01 + sx(pb_q.nsu2));
    res_d.r02 = to_out(pb_q.m02 + sx(pb_q.su1));
    res_d.r10 = to_out(pb_q.m01 + sx(pb_q.su2));
    res_d.r11 = to_out(pb_q.m11 + sx(pb_q.c));
    res_d.r12 = to_out(pb_q.m12 + sx(pb_q.nsu0));
    res_d.r20 = to_out(pb_q.m02 + sx(pb_q.nsu1));
    res_d.r21 = to_out(pb_q.m12 + sx(pb_q.su0));
    res_d.r22 = to_out(pb_q.m22 + sx(pb_q.c));
    res_d.zero_axis = 1'b0;
    if (pb_q.zero) begin
      res_d     = '0;
      res_d.r00 = ident;
      res_d.r11 = ident;
      res_d.r22 = ident;
      res_d.zero_axis = 1'b1;
    end
  end

  aarm_pipe #(.Width($bits(aarm_pkg::out_t))) u_out (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(pb_v), .data_i(res_d),
    .valid_o(out_valid_o), .data_o(out_data_o)
  );

  // A held result stays put; the pipe stalls exactly when output is held.
  `ARM_ASSERT(a_ready_stall, clk_i, rst_ni, in_ready_o == (!out_valid_o || out_ready_i))
  `ARM_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_data_o))
  `ARM_ASSERT_NEXT(a_zero_ident, clk_i, rst_ni, adv && pb_v && pb_q.zero,
                   out_data_o.zero_axis && out_data_o.r01 == '0)
endmodule
`default_nettype wire
